[hw/rtl/bbcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcd_pkg
// Shared types and constants of the buffer cache directory.
// ----------------------------------------------------------------------------
package bbcd_pkg;

  localparam int SLOTS_DEF = 32;
  localparam logic [7:0] CNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [7:0]  tdev;
    logic [31:0] tblk;
    logic        in_use;
    logic        dv;
    logic [7:0]  cnt;
    logic [31:0] ft;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic exec;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic stop;
  } dp_sts_t;

endpackage

[hw/rtl/bbcd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcd_ctrl
// Sequencer: accept, slot scan (reads only), execute, hand result to the output register.
// ----------------------------------------------------------------------------
module bbcd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bbcd_pkg::dp_sts_t  sts,
  output bbcd_pkg::ctl_cmd_t cmd
);
  import bbcd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.is_read ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.stop) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for room in the output register
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/bbcd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcd_dp
// Slot memory, scan comparators, count update and result registers.
// ----------------------------------------------------------------------------
module bbcd_dp #(
  parameter int SLOTS = bbcd_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bbcd_pkg::ctl_cmd_t cmd,
  output bbcd_pkg::dp_sts_t  sts,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_dev,
  input  logic [31:0]        in_block,
  input  logic [4:0]         in_slot_in,
  input  logic [31:0]        in_now,
  output logic [4:0]         out_slot_out,
  output logic               out_hit,
  output logic               out_needs_fill,
  output logic [1:0]         out_status
);
  import bbcd_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  entry_t          mem [SLOTS];
  logic            vld_r [SLOTS];
  entry_t          rd_r;
  logic            rd_v_r;
  entry_t          ent;

  logic [1:0]      op_r;
  logic [7:0]      dev_r;
  logic [31:0]     blk_r;
  logic [4:0]      slot_r;
  logic [31:0]     now_r;
  logic            in_rng_r;

  logic [IW-1:0]   idx_r, eidx_r, raddr;
  logic            hit_r, found_r;
  logic [IW-1:0]   hidx_r, vidx_r;
  entry_t          sav_r;
  logic [31:0]     best_r;

  logic            hit_now, take_now;
  logic            wr_en;
  logic [IW-1:0]   waddr;
  entry_t          wdata;
  logic [4:0]      res_slot;
  logic            res_hit, res_fill;
  status_t         res_st;

  assign ent = rd_v_r ? rd_r : '0;
  assign raddr = cmd.accept ? ((in_op == OP_READ) ? '0 : IW'(in_slot_in)) : idx_r;

  assign hit_now  = ent.in_use && (ent.tdev == dev_r) && (ent.tblk == blk_r);
  assign take_now = (ent.cnt == 8'd0) && (!found_r || (ent.ft < best_r));

  assign sts.is_read = (in_op == OP_READ);
  assign sts.stop    = hit_now || (eidx_r == LAST);

  // memory: unwritten entries read as zero through the valid bits
  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) vld_r[i] <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[waddr] <= 1'b1;
      rd_v_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.accept) begin
      hit_r   <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan) begin
      if (hit_now) begin
        hit_r <= 1'b1;
      end else if (take_now) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eidx_r <= raddr;
    idx_r  <= raddr + IW'(1);
    if (cmd.accept) begin
      op_r     <= in_op;
      dev_r    <= in_dev;
      blk_r    <= in_block;
      slot_r   <= in_slot_in;
      now_r    <= in_now;
      in_rng_r <= (32'(in_slot_in) < SLOTS);
    end
    if (cmd.scan) begin
      if (hit_now) begin
        hidx_r <= eidx_r;
        sav_r  <= ent;
      end else if (take_now) begin
        vidx_r <= eidx_r;
        best_r <= ent.ft;
      end
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    waddr    = IW'(slot_r);
    wdata    = ent;
    res_slot = slot_r;
    res_hit  = 1'b0;
    res_fill = 1'b0;
    res_st   = ST_OK;
    if (op_r == OP_READ) begin
      if (hit_r) begin
        wr_en     = cmd.exec;
        waddr     = hidx_r;
        wdata     = sav_r;
        wdata.dv  = 1'b1;
        if (sav_r.cnt != CNT_MAX) wdata.cnt = sav_r.cnt + 8'd1;
        res_slot  = 5'(hidx_r);
        res_hit   = 1'b1;
        res_fill  = !sav_r.dv;
      end else if (found_r) begin
        wr_en        = cmd.exec;
        waddr        = vidx_r;
        wdata.tdev   = dev_r;
        wdata.tblk   = blk_r;
        wdata.in_use = 1'b1;
        wdata.dv     = 1'b1;
        wdata.cnt    = 8'd1;
        wdata.ft     = best_r;
        res_slot     = 5'(vidx_r);
        res_fill     = 1'b1;
      end else begin
        res_slot = '0;
        res_st   = ST_NOFREE;
      end
    end else if (in_rng_r) begin
      if (op_r == OP_PIN) begin
        wr_en = cmd.exec;
        if (ent.cnt != CNT_MAX) wdata.cnt = ent.cnt + 8'd1;
      end else if (ent.cnt == 8'd0) begin
        res_st = ST_UNDER;
      end else begin
        wr_en     = cmd.exec;
        wdata.cnt = ent.cnt - 8'd1;
        // only a release stamps the free time
        if (op_r == OP_RELEASE && ent.cnt == 8'd1) wdata.ft = now_r;
      end
    end
  end

  // result held from execute until loaded into the output register
  logic [4:0] rs_slot_r;
  logic       rs_hit_r, rs_fill_r;
  logic [1:0] rs_st_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rs_slot_r <= res_slot;
      rs_hit_r  <= res_hit;
      rs_fill_r <= res_fill;
      rs_st_r   <= res_st;
    end
    if (cmd.load_out) begin
      out_slot_out   <= rs_slot_r;
      out_hit        <= rs_hit_r;
      out_needs_fill <= rs_fill_r;
      out_status     <= rs_st_r;
    end
  end

endmodule

[hw/rtl/block_buffer_cache_directory.sv]
`timescale 1ns / 1ps
// Scan: a read scans the slot memory, one slot memory read per cycle, with early
//   exit on a hit; release/pin/unpin skip the scan.
// Throughput: one word at a time; next word accepted the cycle after the result
//   is loaded into the output register, which waits while the output stalls.
// Reset: rst_n synchronous active low clears the FSM, output valid and the
//   per-slot valid bits, so every slot reads as zero after reset.
// ----------------------------------------------------------------------------
// block_buffer_cache_directory
// Buffer cache directory with reference counts and oldest-free replacement.
// ----------------------------------------------------------------------------
module block_buffer_cache_directory #(
  parameter int SLOTS = bbcd_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_dev,
  input  logic [31:0] in_block,
  input  logic [4:0]  in_slot_in,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_slot_out,
  output logic        out_hit,
  output logic        out_needs_fill,
  output logic [1:0]  out_status
);
  import bbcd_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bbcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbcd_dp #(.SLOTS(SLOTS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_dev        (in_dev),
    .in_block      (in_block),
    .in_slot_in    (in_slot_in),
    .in_now        (in_now),
    .out_slot_out  (out_slot_out),
    .out_hit       (out_hit),
    .out_needs_fill(out_needs_fill),
    .out_status    (out_status)
  );

endmodule

[hw/rtl/bbcd_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcd_chk
// Port-level checks of the buffer cache directory.
// ----------------------------------------------------------------------------
module bbcd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_slot_out,
  input logic       out_hit,
  input logic       out_needs_fill,
  input logic [1:0] out_status
);
  import bbcd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot_out) && $stable(out_status))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK)
    else $error("hit with error status");

  a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOFREE |-> out_slot_out == 5'd0 && !out_hit && !out_needs_fill)
    else $error("no-free result not cleared");

endmodule

bind block_buffer_cache_directory bbcd_chk u_bbcd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_slot_out  (out_slot_out),
  .out_hit       (out_hit),
  .out_needs_fill(out_needs_fill),
  .out_status    (out_status)
);
